FILE: hdl/esd_pkg.sv
// Shared types, character constants and helper functions for the escape
// sequence decoder. No dependencies.
`default_nettype none

package esd_pkg;

  // Decoder mode, one-hot.
  typedef enum logic [5:0] {
    MODE_NORMAL = 6'b000001,
    MODE_ESC    = 6'b000010,
    MODE_HEX0   = 6'b000100,
    MODE_HEX1   = 6'b001000,
    MODE_OCT1   = 6'b010000,
    MODE_OCT2   = 6'b100000
  } esd_mode_t;

  // One result item as held in the result buffer.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eoo;
    logic       last;
  } esd_res_t;

  localparam int unsigned ResSlots = 3;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;
  localparam logic [7:0] CHAR_E      = 8'h65;
  localparam logic [7:0] CHAR_X      = 8'h78;

  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_ESC = 8'd27;

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Letters a-f and A-F both have 1..6 in the low nibble.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/escape_sequence_decoder_unit.sv
// Top level of the C-style escape sequence decoder: input register, decode
// state, result buffer and output handshake. Depends on esd_pkg, esd_decode.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one encoded character per
//   item in in_char, with end_of_input set on the final character of a
//   string. The output channel (out_valid/out_ready) carries decoded items:
//   a byte with byte_valid set, or the end marker with end_of_output set.
//   last_of_run marks the last result item caused by one input item; an
//   input item causes zero to three results.
//   Path: an accepted input item waits in the input register and is decoded
//   into the result buffer once that buffer is empty or is handing over its
//   final item; its first result is then offered from slot zero.
//   Throughput: one input item per cycle as long as each item yields at most
//   one result and the receiver keeps out_ready high. An item with two or
//   three results holds the result buffer until its final result is taken;
//   the single-entry input register keeps taking one more item meanwhile.
//   Stall: when out_ready is low the result buffer holds, the input register
//   fills, and in_ready drops until the buffer's final result is taken.
//   Reset (rst, synchronous, active high) returns the decoder to the normal
//   mode with a zero pending value and empties both the input register and
//   the result buffer.
`default_nettype none

module escape_sequence_decoder_unit (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       in_valid,
  output logic           in_ready,
  input  var logic [7:0] in_char,
  input  var logic       end_of_input,
  output logic           out_valid,
  input  var logic       out_ready,
  output logic [7:0]     out_byte,
  output logic           byte_valid,
  output logic           end_of_output,
  output logic           last_of_run
);

  // Input register: one character waiting to be decoded.
  logic       in_full;
  logic [7:0] in_char_q;
  logic       in_eoi_q;

  // Decoder state carried from one character to the next.
  esd_pkg::esd_mode_t mode;
  logic [7:0]         pending;

  // Result buffer: up to three items, the head always in slot zero.
  esd_pkg::esd_res_t res_buf [esd_pkg::ResSlots];
  logic [1:0]        count;

  esd_pkg::esd_res_t  dec_res [esd_pkg::ResSlots];
  logic [1:0]         dec_count;
  esd_pkg::esd_mode_t mode_next;
  logic [7:0]         pending_next;

  logic pop;
  logic load;

  esd_decode u_decode (
    .mode         (mode),
    .pending      (pending),
    .in_char      (in_char_q),
    .end_of_input (in_eoi_q),
    .res          (dec_res),
    .res_count    (dec_count),
    .mode_next    (mode_next),
    .pending_next (pending_next)
  );

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;

  // The buffered character is decoded once the result buffer is empty or is
  // handing over its final item in this cycle.
  assign load     = in_full && ((count == 2'd0) || ((count == 2'd1) && out_ready));
  assign in_ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_q <= in_char;
      in_eoi_q  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= esd_pkg::MODE_NORMAL;
      pending <= 8'd0;
    end else if (load) begin
      mode    <= mode_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= dec_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // Payload of the buffer: a load replaces it, a pop shifts it down.
  always_ff @(posedge clk) begin
    if (load) begin
      res_buf <= dec_res;
    end else if (pop) begin
      res_buf[0] <= res_buf[1];
      res_buf[1] <= res_buf[2];
    end
  end

  assign out_byte      = res_buf[0].data;
  assign byte_valid    = res_buf[0].valid;
  assign end_of_output = res_buf[0].eoo;
  assign last_of_run   = res_buf[0].last;

`ifndef NO_ASSERTIONS
  // The final character of a string always leaves the decoder clean.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (load && in_eoi_q) |=> ((mode == esd_pkg::MODE_NORMAL) && (pending == 8'd0)))
    else $error("decoder state not cleared after final character");

  // The end marker is never a data byte and always closes its run.
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_output) |-> (!byte_valid && last_of_run))
    else $error("malformed end marker");

  // Without a decode the buffer only drains.
  a_no_growth: assert property (@(posedge clk) disable iff (rst)
    !load |=> (count <= $past(count)))
    else $error("result buffer grew without a decode");
`endif

endmodule

`default_nettype wire

FILE: hdl/esd_decode.sv
// Combinational decode of one character against the current mode and pending
// value; produces up to three packed result items. Depends on esd_pkg.
`default_nettype none

module esd_decode (
  input  var esd_pkg::esd_mode_t mode,
  input  var logic [7:0]         pending,
  input  var logic [7:0]         in_char,
  input  var logic               end_of_input,
  output esd_pkg::esd_res_t      res [esd_pkg::ResSlots],
  output logic [1:0]             res_count,
  output esd_pkg::esd_mode_t     mode_next,
  output logic [7:0]             pending_next
);

  always_comb begin
    logic               plain_esc;
    logic               flush_en;
    logic               char_en;
    logic               end_flush_en;
    logic [7:0]         char_val;
    esd_pkg::esd_mode_t mode_tmp;
    logic [7:0]         pend_tmp;
    esd_pkg::esd_res_t  cand [4];
    logic               cand_en [4];
    logic [1:0]         k;

    plain_esc = (in_char == esd_pkg::CHAR_BSLASH);
    flush_en  = 1'b0;
    char_en   = 1'b0;
    char_val  = in_char;
    mode_tmp  = mode;
    pend_tmp  = pending;

    case (mode)
      esd_pkg::MODE_ESC: begin
        mode_tmp = esd_pkg::MODE_NORMAL;
        char_en  = 1'b1;
        case (in_char)
          esd_pkg::CHAR_BSLASH: char_val = esd_pkg::CHAR_BSLASH;
          esd_pkg::CHAR_QUOTE:  char_val = esd_pkg::CHAR_QUOTE;
          esd_pkg::CHAR_N:      char_val = esd_pkg::BYTE_LF;
          esd_pkg::CHAR_R:      char_val = esd_pkg::BYTE_CR;
          esd_pkg::CHAR_T:      char_val = esd_pkg::BYTE_TAB;
          esd_pkg::CHAR_E:      char_val = esd_pkg::BYTE_ESC;
          esd_pkg::CHAR_X: begin
            char_en  = 1'b0;
            mode_tmp = esd_pkg::MODE_HEX0;
          end
          default: begin
            if (esd_pkg::is_oct(in_char)) begin
              char_en  = 1'b0;
              pend_tmp = {5'd0, in_char[2:0]};
              mode_tmp = esd_pkg::MODE_OCT1;
            end
          end
        endcase
      end
      esd_pkg::MODE_HEX0: begin
        if (esd_pkg::is_hex(in_char)) begin
          pend_tmp = {4'd0, esd_pkg::hex_val(in_char)};
          mode_tmp = esd_pkg::MODE_HEX1;
        end else begin
          char_en  = !plain_esc;
          mode_tmp = plain_esc ? esd_pkg::MODE_ESC : esd_pkg::MODE_NORMAL;
        end
      end
      esd_pkg::MODE_HEX1: begin
        if (esd_pkg::is_hex(in_char)) begin
          char_en  = 1'b1;
          char_val = {pending[3:0], esd_pkg::hex_val(in_char)};
          mode_tmp = esd_pkg::MODE_NORMAL;
        end else begin
          flush_en = 1'b1;
          char_en  = !plain_esc;
          mode_tmp = plain_esc ? esd_pkg::MODE_ESC : esd_pkg::MODE_NORMAL;
        end
      end
      esd_pkg::MODE_OCT1: begin
        if (esd_pkg::is_oct(in_char)) begin
          pend_tmp = {pending[4:0], in_char[2:0]};
          mode_tmp = esd_pkg::MODE_OCT2;
        end else begin
          flush_en = 1'b1;
          char_en  = !plain_esc;
          mode_tmp = plain_esc ? esd_pkg::MODE_ESC : esd_pkg::MODE_NORMAL;
        end
      end
      esd_pkg::MODE_OCT2: begin
        if (esd_pkg::is_oct(in_char)) begin
          char_en  = 1'b1;
          char_val = {pending[4:0], in_char[2:0]};
          mode_tmp = esd_pkg::MODE_NORMAL;
        end else begin
          flush_en = 1'b1;
          char_en  = !plain_esc;
          mode_tmp = plain_esc ? esd_pkg::MODE_ESC : esd_pkg::MODE_NORMAL;
        end
      end
      default: begin
        char_en  = !plain_esc;
        mode_tmp = plain_esc ? esd_pkg::MODE_ESC : esd_pkg::MODE_NORMAL;
      end
    endcase

    // At the end of the string an escape still collecting digits is flushed.
    end_flush_en = end_of_input &&
                   ((mode_tmp == esd_pkg::MODE_HEX1) || (mode_tmp == esd_pkg::MODE_OCT1) ||
                    (mode_tmp == esd_pkg::MODE_OCT2));

    cand[0]    = '{data: pending,  valid: 1'b1, eoo: 1'b0, last: 1'b0};
    cand_en[0] = flush_en;
    cand[1]    = '{data: char_val, valid: 1'b1, eoo: 1'b0, last: 1'b0};
    cand_en[1] = char_en;
    cand[2]    = '{data: pend_tmp, valid: 1'b1, eoo: 1'b0, last: 1'b0};
    cand_en[2] = end_flush_en;
    cand[3]    = '{data: 8'd0,     valid: 1'b0, eoo: 1'b1, last: 1'b0};
    cand_en[3] = end_of_input;

    for (int j = 0; j < esd_pkg::ResSlots; j++) begin
      res[j] = '0;
    end

    // At most three candidates are ever enabled together.
    k = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_en[i] && (k != 2'd3)) begin
        res[k] = cand[i];
        k      = k + 2'd1;
      end
    end
    res_count = k;

    for (int j = 0; j < esd_pkg::ResSlots; j++) begin
      if ((k != 2'd0) && (2'(j) == (k - 2'd1))) begin
        res[j].last = 1'b1;
      end
    end

    if (end_of_input) begin
      mode_next    = esd_pkg::MODE_NORMAL;
      pending_next = 8'd0;
    end else begin
      mode_next    = mode_tmp;
      pending_next = pend_tmp;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for escape_sequence_decoder_unit: random escaped strings in,
// decoded bytes and end markers checked against an in-bench decoder model.
// Depends on esd_pkg and the RTL of the decoder only.
`timescale 1ns / 100ps

module tb;

  // One character waiting to be offered. When hold_for_drain is set, the
  // sender waits until every expected result has come before offering it.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         hold_for_drain;
  } pending_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h20;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_output;
  logic       last_of_run;

  escape_sequence_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char       (in_char),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_output (end_of_output),
    .last_of_run   (last_of_run)
  );

  always #2 clk = ~clk;

  pending_char_t       pending_chars[$];
  logic [7:0]          text_buf[$];
  esd_pkg::esd_res_t   expected_bytes[$];

  // Decoder state as the testbench sees it.
  esd_pkg::esd_mode_t dec_mode = esd_pkg::MODE_NORMAL;
  logic [7:0]         dec_value = 8'h00;

  int  failures = 0;
  int  chars_sent = 0;
  int  strings_done = 0;
  int  results_checked = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  bit  in_accepted = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder model. Every accepted item is run through decode_char, which
  // appends the results it causes to expected_bytes and marks the last one.
  // ---------------------------------------------------------------------------

  function automatic void emit_byte(logic [7:0] b, logic valid, logic eoo);
    esd_pkg::esd_res_t r;
    r.data  = b;
    r.valid = valid;
    r.eoo   = eoo;
    r.last  = 1'b0;
    expected_bytes.insert(expected_bytes.size(), r);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit is_octal_digit(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  // A character seen in the normal mode: a backslash opens an escape, anything
  // else is passed through as it is.
  function automatic void plain_char(logic [7:0] c);
    if (c == esd_pkg::CHAR_BSLASH) begin
      dec_mode = esd_pkg::MODE_ESC;
    end else begin
      dec_mode = esd_pkg::MODE_NORMAL;
      emit_byte(c, 1'b1, 1'b0);
    end
  endfunction

  function automatic void decode_char(logic [7:0] c, logic eoi);
    int n_prior;
    int h;
    n_prior = expected_bytes.size();
    h = hex_digit(c);
    case (dec_mode)
      esd_pkg::MODE_ESC: begin
        dec_mode = esd_pkg::MODE_NORMAL;
        case (c)
          esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_QUOTE: emit_byte(c, 1'b1, 1'b0);
          esd_pkg::CHAR_N: emit_byte(esd_pkg::BYTE_LF, 1'b1, 1'b0);
          esd_pkg::CHAR_R: emit_byte(esd_pkg::BYTE_CR, 1'b1, 1'b0);
          esd_pkg::CHAR_T: emit_byte(esd_pkg::BYTE_TAB, 1'b1, 1'b0);
          esd_pkg::CHAR_E: emit_byte(esd_pkg::BYTE_ESC, 1'b1, 1'b0);
          esd_pkg::CHAR_X: dec_mode = esd_pkg::MODE_HEX0;
          default: begin
            if (is_octal_digit(c)) begin
              dec_value = c - "0";
              dec_mode = esd_pkg::MODE_OCT1;
            end else begin
              // Unknown escape: the backslash is dropped, the character kept.
              emit_byte(c, 1'b1, 1'b0);
            end
          end
        endcase
      end
      esd_pkg::MODE_HEX0: begin
        if (h >= 0) begin
          dec_value = h[7:0];
          dec_mode = esd_pkg::MODE_HEX1;
        end else begin
          plain_char(c);
        end
      end
      esd_pkg::MODE_HEX1: begin
        if (h >= 0) begin
          emit_byte({dec_value[3:0], h[3:0]}, 1'b1, 1'b0);
          dec_mode = esd_pkg::MODE_NORMAL;
        end else begin
          emit_byte(dec_value, 1'b1, 1'b0);
          plain_char(c);
        end
      end
      esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: begin
        if (is_octal_digit(c) && dec_mode == esd_pkg::MODE_OCT1) begin
          dec_value = {dec_value[4:0], c[2:0]};
          dec_mode = esd_pkg::MODE_OCT2;
        end else if (is_octal_digit(c)) begin
          // Third octal digit; anything above 8 bits is dropped.
          emit_byte({dec_value[4:0], c[2:0]}, 1'b1, 1'b0);
          dec_mode = esd_pkg::MODE_NORMAL;
        end else begin
          emit_byte(dec_value, 1'b1, 1'b0);
          plain_char(c);
        end
      end
      default: plain_char(c);
    endcase

    if (eoi) begin
      if (dec_mode == esd_pkg::MODE_HEX1 || dec_mode == esd_pkg::MODE_OCT1 ||
          dec_mode == esd_pkg::MODE_OCT2)
        emit_byte(dec_value, 1'b1, 1'b0);
      emit_byte(8'h00, 1'b0, 1'b1);
      dec_mode = esd_pkg::MODE_NORMAL;
      dec_value = 8'h00;
    end

    if (expected_bytes.size() > n_prior)
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction. Characters are collected in text_buf and then moved
  // to the sender's queue, with end_of_input on the last one if asked.
  // ---------------------------------------------------------------------------

  function automatic void put_text(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  task automatic flush_text(bit eoi_last, bit drain_first);
    pending_char_t p;
    for (int i = 0; i < text_buf.size(); i++) begin
      p.ch = text_buf[i];
      p.eoi = eoi_last && (i == text_buf.size() - 1);
      p.hold_for_drain = drain_first && (i == 0);
      pending_chars.insert(pending_chars.size(), p);
    end
    text_buf.delete();
  endtask

  task automatic queue_str(string s, bit eoi_last);
    for (int i = 0; i < s.len(); i++)
      put_text(s[i]);
    flush_text(eoi_last, 1'b0);
  endtask

  // A random string of well-formed escapes with random content, mixed with
  // some noise: unknown escapes, lone backslashes and arbitrary characters.
  task automatic build_random_string();
    int         segs;
    int         nd;
    int         v;
    logic [7:0] simple_esc[6];
    simple_esc = '{esd_pkg::CHAR_BSLASH, esd_pkg::CHAR_QUOTE, esd_pkg::CHAR_N,
                   esd_pkg::CHAR_R, esd_pkg::CHAR_T, esd_pkg::CHAR_E};
    segs = $urandom_range(1, 10);
    for (int s = 0; s < segs; s++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: put_text(8'($urandom_range(1, 255)));
        3: begin
          put_text(esd_pkg::CHAR_BSLASH);
          put_text(simple_esc[$urandom_range(0, 5)]);
        end
        4, 5: begin
          put_text(esd_pkg::CHAR_BSLASH);
          put_text(esd_pkg::CHAR_X);
          nd = $urandom_range(0, 2);
          for (int d = 0; d < nd; d++) begin
            v = $urandom_range(0, 15);
            if (v < 10)
              put_text(8'("0" + v));
            else if ($urandom_range(0, 1))
              put_text(8'("a" + v - 10));
            else
              put_text(8'("A" + v - 10));
          end
        end
        6, 7: begin
          put_text(esd_pkg::CHAR_BSLASH);
          nd = $urandom_range(1, 3);
          for (int d = 0; d < nd; d++)
            put_text(8'("0" + $urandom_range(0, 7)));
        end
        8: begin
          put_text(esd_pkg::CHAR_BSLASH);
          put_text(8'($urandom_range(1, 255)));
        end
        default: put_text(esd_pkg::CHAR_BSLASH);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. At each falling edge it holds the item on offer, idles for a burst
  // of cycles, waits for results to drain, or offers the next queued character.
  // Idle bursts stop below 40 queued characters, so the run ends at full rate.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // Item still on offer; valid and payload stay as they are.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_chars.size() >= 40 && $urandom_range(0, 5) == 0) begin
      send_gap = $urandom_range(1, 5) - 1;
      in_valid <= 1'b0;
    end else if (pending_chars.size() != 0 &&
                 !(pending_chars[0].hold_for_drain && expected_bytes.size() != 0)) begin
      in_valid <= 1'b1;
      in_char <= pending_chars[0].ch;
      end_of_input <= pending_chars[0].eoi;
      void'(pending_chars.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Random stall bursts, plus one long hold-off in the middle of the
  // run while the sender keeps offering, so the input register and result
  // buffer fill up and in_ready has to drop.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_checked >= 150) begin
      long_hold_done = 1'b1;
      hold_left = 39;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (pending_chars.size() >= 40 && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Accepted inputs feed the model; accepted results are checked
  // field by field against the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    esd_pkg::esd_res_t want;
    in_accepted <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      decode_char(in_char, end_of_input);
      chars_sent++;
      if (end_of_input) strings_done++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("result item with nothing expected: out_byte %h byte_valid %b end_of_output %b",
               out_byte, byte_valid, end_of_output);
        failures++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, out_byte);
          failures++;
        end
        if (byte_valid !== want.valid) begin
          $error("byte_valid: expected %b, actual %b", want.valid, byte_valid);
          failures++;
        end
        if (end_of_output !== want.eoo) begin
          $error("end_of_output: expected %b, actual %b", want.eoo, end_of_output);
          failures++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %b, actual %b", want.last, last_of_run);
          failures++;
        end
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build all stimulus, release reset, wait for the sender and
  // the expected results to drain, then report.
  // ---------------------------------------------------------------------------

  initial begin
    // Directed part: extreme characters, an unknown escape, hex with mixed
    // case, hex cut short, \x with no digit followed by a new escape, octal
    // overflow, two octal digits cut short by another escape, and strings
    // that end on a lone backslash, a bare \x and a single hex digit.
    put_text(8'h01);
    put_text(8'hFF);
    flush_text(1'b0, 1'b0);
    queue_str("\\q\\xAf\\x5g\\x\\n\\777\\12\\e", 1'b1);
    queue_str("\\", 1'b1);
    queue_str("\\x", 1'b1);
    queue_str("\\x5", 1'b1);

    // Random part. A random string begun at under 40 or at 230 to 244 queued
    // characters waits until the block has delivered everything before starting.
    while (pending_chars.size() < 360) begin
      build_random_string();
      flush_text(1'b1, text_buf.size() != 0 &&
                 (pending_chars.size() < 40 ||
                  (pending_chars.size() >= 230 && pending_chars.size() < 245)));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_bytes.size() != 0);

    // Anything the block still produces now has no expectation and fails.
    repeat (8) @(posedge clk);

    $display("Summary: %0d characters in %0d strings decoded, %0d result items checked.",
             chars_sent, strings_done, results_checked);
    if (failures == 0 && expected_bytes.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("tb failed");
    $finish;
  end

endmodule
